>>> rtl/dnsrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DNS response parser package
// Result kinds, header and record constants, and the result payload type.
// ----------------------------------------------------------------------------
package dnsrp_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_RCODE   = 2'd1;
   localparam logic [1:0] KIND_ADDRESS = 2'd2;
   localparam logic [1:0] KIND_BADTYPE = 2'd3;

   localparam logic [15:0] RCODE_MASK   = 16'h000F;
   localparam logic [7:0]  POINTER_MASK = 8'hC0;

   localparam logic [15:0] TYPE_A    = 16'd1;
   localparam logic [15:0] TYPE_AAAA = 16'd28;

   // byte_in_field values that close header fields
   localparam logic [4:0] HDR_FLAGS_DONE = 5'd3;
   localparam logic [4:0] HDR_LAST_BYTE  = 5'd11;

   // fixed field lengths in bytes
   localparam logic [4:0] LEN_WORD  = 5'd2;
   localparam logic [4:0] LEN_QTAIL = 5'd4;
   localparam logic [4:0] LEN_TTL   = 5'd4;
   localparam logic [4:0] LEN_IPV4  = 5'd4;
   localparam logic [4:0] LEN_IPV6  = 5'd16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] msg_id;
      logic [15:0] flags_word;
      logic [15:0] question_count;
      logic [15:0] answer_count;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] time_to_live;
      logic [15:0] data_length;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic        last;
   } rsp_payload_type;

endpackage
`default_nettype wire

>>> rtl/dns_response_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Output: a result is registered in the output register, or in the skid entry while rsp_stall
//   holds the output, on the transfer of the byte that completes it.
// Throughput: one byte per cycle while req_stall is low; an output register plus one skid
//   entry means req_stall rises only while two results are held back by rsp_stall.
// Reset: synchronous; parser goes idle and ignores bytes until a start-of-message byte.
// ----------------------------------------------------------------------------
// DNS response parser unit
// Byte-wide parse of a DNS response: header, question skip, A/AAAA answers, RCODE and bad-type errors.
// ----------------------------------------------------------------------------
module dns_response_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_message,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_kind,
   output      logic [15:0] rsp_msg_id,
   output      logic [15:0] rsp_flags_word,
   output      logic [15:0] rsp_question_count,
   output      logic [15:0] rsp_answer_count,
   output      logic [15:0] rsp_record_type,
   output      logic [15:0] rsp_record_class,
   output      logic [31:0] rsp_time_to_live,
   output      logic [15:0] rsp_data_length,
   output      logic [63:0] rsp_address_high,
   output      logic [63:0] rsp_address_low,
   output      logic        rsp_last
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_HEADER, PH_QNAME, PH_QTAIL, PH_ANAME,
      PH_TYPE, PH_CLASS, PH_TTL, PH_LEN, PH_ADDR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  bif_ff, bif_in;
   logic [15:0] hdr_id_ff, hdr_id_in;
   logic [15:0] hdr_flags_ff, hdr_flags_in;
   logic [15:0] q_total_ff, q_total_in;
   logic [15:0] a_total_ff, a_total_in;
   logic [15:0] q_left_ff, q_left_in;
   logic [15:0] a_left_ff, a_left_in;
   logic [7:0]  lbl_left_ff, lbl_left_in;
   logic [15:0] cur_type_ff, cur_type_in;
   logic [15:0] cur_class_ff, cur_class_in;
   logic [31:0] cur_ttl_ff, cur_ttl_in;
   logic [15:0] cur_len_ff, cur_len_in;
   logic [63:0] addr_hi_ff, addr_hi_in;
   logic [63:0] addr_lo_ff, addr_lo_in;

   logic        out_valid_ff, skid_valid_ff;
   dnsrp_pkg::rsp_payload_type out_ff, skid_ff, result;

   logic        req_accept, out_free;
   logic        emit;
   logic [1:0]  emit_kind;
   logic        emit_last;
   logic [4:0]  bif_step, field_len;
   logic        field_done, name_end, is_record;
   logic [7:0]  d;

   assign d          = req_data_byte;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_free   = !out_valid_ff || !rsp_stall;

   always_comb begin
      phase_in     = phase_ff;
      bif_in       = bif_ff;
      hdr_id_in    = hdr_id_ff;
      hdr_flags_in = hdr_flags_ff;
      q_total_in   = q_total_ff;
      a_total_in   = a_total_ff;
      q_left_in    = q_left_ff;
      a_left_in    = a_left_ff;
      lbl_left_in  = lbl_left_ff;
      cur_type_in  = cur_type_ff;
      cur_class_in = cur_class_ff;
      cur_ttl_in   = cur_ttl_ff;
      cur_len_in   = cur_len_ff;
      addr_hi_in   = addr_hi_ff;
      addr_lo_in   = addr_lo_ff;
      emit         = 1'b0;
      emit_kind    = dnsrp_pkg::KIND_HEADER;
      emit_last    = 1'b0;
      name_end     = 1'b0;
      field_done   = 1'b0;

      if (req_start_of_message) begin
         phase_in     = PH_HEADER;
         bif_in       = '0;
         hdr_id_in    = '0;
         hdr_flags_in = '0;
         q_total_in   = '0;
         a_total_in   = '0;
         q_left_in    = '0;
         a_left_in    = '0;
         lbl_left_in  = '0;
         cur_type_in  = '0;
         cur_class_in = '0;
         cur_ttl_in   = '0;
         cur_len_in   = '0;
         addr_hi_in   = '0;
         addr_lo_in   = '0;
      end

      bif_step = bif_in + 5'd1;

      // name skipping: pointer second byte, label body, zero terminator, new label or pointer first byte
      if (bif_in != 5'd0) begin
         name_end = 1'b1;
      end else if (lbl_left_in != 8'd0) begin
         name_end = 1'b0;
      end else if (d == 8'd0) begin
         name_end = 1'b1;
      end else begin
         name_end = 1'b0;
      end

      case (phase_in)
         PH_QTAIL:                     field_len = dnsrp_pkg::LEN_QTAIL;
         PH_TTL:                       field_len = dnsrp_pkg::LEN_TTL;
         PH_ADDR:                      field_len = (cur_type_in == dnsrp_pkg::TYPE_A) ?
                                                   dnsrp_pkg::LEN_IPV4 : dnsrp_pkg::LEN_IPV6;
         default:                      field_len = dnsrp_pkg::LEN_WORD;
      endcase
      field_done = (bif_step >= field_len);

      case (phase_in)
         PH_HEADER: begin
            case (bif_in[4:1])
               4'd0:    hdr_id_in    = {hdr_id_in[7:0], d};
               4'd1:    hdr_flags_in = {hdr_flags_in[7:0], d};
               4'd2:    q_total_in   = {q_total_in[7:0], d};
               4'd3:    a_total_in   = {a_total_in[7:0], d};
               default: ;
            endcase
            bif_in = bif_step;
            if (bif_step == dnsrp_pkg::HDR_FLAGS_DONE + 5'd1 &&
                (hdr_flags_in & dnsrp_pkg::RCODE_MASK) != 16'd0) begin
               phase_in  = PH_IDLE;
               bif_in    = '0;
               emit      = 1'b1;
               emit_kind = dnsrp_pkg::KIND_RCODE;
               emit_last = 1'b1;
            end else if (bif_step == dnsrp_pkg::HDR_LAST_BYTE + 5'd1) begin
               bif_in    = '0;
               q_left_in = q_total_in;
               a_left_in = a_total_in;
               if (a_total_in == 16'd0) begin
                  phase_in = PH_IDLE;
               end else if (q_total_in != 16'd0) begin
                  phase_in = PH_QNAME;
               end else begin
                  phase_in = PH_ANAME;
               end
               emit      = 1'b1;
               emit_kind = dnsrp_pkg::KIND_HEADER;
               emit_last = (a_total_in == 16'd0);
            end
         end
         PH_QNAME, PH_ANAME: begin
            if (bif_in != 5'd0) begin
               bif_in = '0;
            end else if (lbl_left_in != 8'd0) begin
               lbl_left_in = lbl_left_in - 8'd1;
            end else if (d == 8'd0) begin
               lbl_left_in = lbl_left_in;
            end else if ((d & dnsrp_pkg::POINTER_MASK) != 8'd0) begin
               bif_in = 5'd1;
            end else begin
               lbl_left_in = d;
            end
            if (name_end) begin
               if (phase_in == PH_QNAME) begin
                  phase_in = PH_QTAIL;
               end else begin
                  cur_type_in  = '0;
                  cur_class_in = '0;
                  cur_ttl_in   = '0;
                  cur_len_in   = '0;
                  addr_hi_in   = '0;
                  addr_lo_in   = '0;
                  phase_in     = PH_TYPE;
               end
            end
         end
         PH_QTAIL: begin
            bif_in = field_done ? 5'd0 : bif_step;
            if (field_done) begin
               q_left_in = q_left_in - 16'd1;
               phase_in  = (q_left_in == 16'd0) ? PH_ANAME : PH_QNAME;
            end
         end
         PH_TYPE: begin
            cur_type_in = {cur_type_in[7:0], d};
            bif_in      = field_done ? 5'd0 : bif_step;
            if (field_done) begin
               if (cur_type_in != dnsrp_pkg::TYPE_A && cur_type_in != dnsrp_pkg::TYPE_AAAA) begin
                  phase_in  = PH_IDLE;
                  emit      = 1'b1;
                  emit_kind = dnsrp_pkg::KIND_BADTYPE;
                  emit_last = 1'b1;
               end else begin
                  phase_in = PH_CLASS;
               end
            end
         end
         PH_CLASS: begin
            cur_class_in = {cur_class_in[7:0], d};
            bif_in       = field_done ? 5'd0 : bif_step;
            if (field_done) phase_in = PH_TTL;
         end
         PH_TTL: begin
            cur_ttl_in = {cur_ttl_in[23:0], d};
            bif_in     = field_done ? 5'd0 : bif_step;
            if (field_done) phase_in = PH_LEN;
         end
         PH_LEN: begin
            cur_len_in = {cur_len_in[7:0], d};
            bif_in     = field_done ? 5'd0 : bif_step;
            if (field_done) phase_in = PH_ADDR;
         end
         PH_ADDR: begin
            addr_hi_in = {addr_hi_in[55:0], addr_lo_in[63:56]};
            addr_lo_in = {addr_lo_in[55:0], d};
            bif_in     = field_done ? 5'd0 : bif_step;
            if (field_done) begin
               a_left_in = a_left_in - 16'd1;
               phase_in  = (a_left_in == 16'd0) ? PH_IDLE : PH_ANAME;
               emit      = 1'b1;
               emit_kind = dnsrp_pkg::KIND_ADDRESS;
               emit_last = (a_left_in == 16'd0);
            end
         end
         PH_IDLE: ;
         default: phase_in = PH_IDLE;
      endcase
   end

   assign is_record = (emit_kind == dnsrp_pkg::KIND_ADDRESS);

   always_comb begin
      result.kind           = emit_kind;
      result.msg_id         = hdr_id_in;
      result.flags_word     = hdr_flags_in;
      result.question_count = q_total_in;
      result.answer_count   = a_total_in;
      result.record_type    = (emit_kind == dnsrp_pkg::KIND_ADDRESS ||
                               emit_kind == dnsrp_pkg::KIND_BADTYPE) ? cur_type_in : 16'd0;
      result.record_class   = is_record ? cur_class_in : 16'd0;
      result.time_to_live   = is_record ? cur_ttl_in : 32'd0;
      result.data_length    = is_record ? cur_len_in : 16'd0;
      result.address_high   = is_record ? addr_hi_in : 64'd0;
      result.address_low    = is_record ? addr_lo_in : 64'd0;
      result.last           = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bif_ff        <= '0;
         hdr_id_ff     <= '0;
         hdr_flags_ff  <= '0;
         q_total_ff    <= '0;
         a_total_ff    <= '0;
         q_left_ff     <= '0;
         a_left_ff     <= '0;
         lbl_left_ff   <= '0;
         cur_type_ff   <= '0;
         cur_class_ff  <= '0;
         cur_ttl_ff    <= '0;
         cur_len_ff    <= '0;
         addr_hi_ff    <= '0;
         addr_lo_ff    <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff     <= phase_in;
            bif_ff       <= bif_in;
            hdr_id_ff    <= hdr_id_in;
            hdr_flags_ff <= hdr_flags_in;
            q_total_ff   <= q_total_in;
            a_total_ff   <= a_total_in;
            q_left_ff    <= q_left_in;
            a_left_ff    <= a_left_in;
            lbl_left_ff  <= lbl_left_in;
            cur_type_ff  <= cur_type_in;
            cur_class_ff <= cur_class_in;
            cur_ttl_ff   <= cur_ttl_in;
            cur_len_ff   <= cur_len_in;
            addr_hi_ff   <= addr_hi_in;
            addr_lo_ff   <= addr_lo_in;
         end
         // skid entry drains first; no transfer is taken while it is full
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= req_accept && emit;
            end
            out_ff <= skid_valid_ff ? skid_ff : result;
         end else if (req_accept && emit) begin
            skid_valid_ff <= 1'b1;
            skid_ff       <= result;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_msg_id         = out_ff.msg_id;
   assign rsp_flags_word     = out_ff.flags_word;
   assign rsp_question_count = out_ff.question_count;
   assign rsp_answer_count   = out_ff.answer_count;
   assign rsp_record_type    = out_ff.record_type;
   assign rsp_record_class   = out_ff.record_class;
   assign rsp_time_to_live   = out_ff.time_to_live;
   assign rsp_data_length    = out_ff.data_length;
   assign rsp_address_high   = out_ff.address_high;
   assign rsp_address_low    = out_ff.address_low;
   assign rsp_last           = out_ff.last;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit && (emit_kind == dnsrp_pkg::KIND_RCODE ||
                              emit_kind == dnsrp_pkg::KIND_BADTYPE)) |-> emit_last)
      else $error("error result not marked last");

   a_record_has_answer: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit && emit_kind == dnsrp_pkg::KIND_ADDRESS) |-> (a_left_ff != 16'd0))
      else $error("address result with no answers left");

   a_idle_field_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (bif_ff == 5'd0))
      else $error("byte counter not cleared while idle");

endmodule
`default_nettype wire
